// File: hw/rtl/bdq_pkg.sv
// Shared types and codes for the bounded double-ended queue.
`default_nettype none

package bdq_pkg;

    // Request modes as they arrive on the request channel.
    typedef logic [2:0] mode_t;
    localparam mode_t MODE_PUSH_FRONT = 3'd0;
    localparam mode_t MODE_PUSH_REAR  = 3'd1;
    localparam mode_t MODE_POP_FRONT  = 3'd2;
    localparam mode_t MODE_POP_REAR   = 3'd3;
    localparam mode_t MODE_LIST       = 3'd4;

    // Operations after classification by the front end.
    typedef logic [2:0] op_t;
    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_REAR  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_REAR   = 3'd3;
    localparam op_t OP_LIST       = 3'd4;
    localparam op_t OP_BAD        = 3'd5;

    // Result status codes.
    typedef logic [2:0] status_t;
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_FULL    = 3'd1;
    localparam status_t ST_EMPTY   = 3'd2;
    localparam status_t ST_NOTHING = 3'd3;
    localparam status_t ST_BAD     = 3'd4;

    // Capacity register width and reset value.
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // One classified request waiting between front and back.
    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/bounded_deque_core.sv
// Top level of the bounded double-ended queue: front end, request queue and back end.
`default_nettype none

// Bounded double-ended queue of signed 32-bit words held in a DEPTH-entry
// circular memory. Requests enter a two-entry queue in the front end, so the
// request channel keeps moving while a result waits on the result channel.
// In the back end a push, a failed pop, a list of an empty queue and a bad
// request each write their result straight into the result register; a pop
// that returns a word passes it through the memory's registered read port
// first; a list reads the first held word, then emits one word per cycle
// while the result channel does not stall. Requests also pass the front queue.
// The memory needs no clearing after reset; only held words are ever read.
// The capacity register may be written only while the block is idle.
module bounded_deque_core #(
    parameter int DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      capacity_we,
    input  wire logic [bdq_pkg::CAP_W-1:0] capacity_wdata,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire logic [2:0]                mode,
    input  wire logic signed [31:0]        value,
    output logic                           res_valid,
    input  wire logic                      res_stall,
    output logic signed [31:0]             value_res,
    output logic [2:0]                     status,
    output logic                           last
);

    logic            q_valid;
    bdq_pkg::entry_t q_entry;
    logic            q_take;

    // Request intake and classification.
    bdq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .mode      (mode),
        .value     (value),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_take    (q_take)
    );

    // Storage and operation sequencing.
    bdq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .q_take         (q_take),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .value_res      (value_res),
        .status         (status),
        .last           (last)
    );

endmodule

`default_nettype wire

// File: hw/rtl/bdq_front.sv
// Front end: accepts requests, classifies the mode and queues them for the back end.
`default_nettype none

module bdq_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [2:0]         mode,
    input  wire logic signed [31:0] value,
    output logic                    q_valid,
    output bdq_pkg::entry_t         q_entry,
    input  wire logic               q_take
);

    bdq_pkg::entry_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;
    logic            accept;
    bdq_pkg::op_t    op_dec;

    // Map the request mode onto an operation; unused modes become a bad request.
    always_comb
    begin
        unique case (mode)
            bdq_pkg::MODE_PUSH_FRONT: op_dec = bdq_pkg::OP_PUSH_FRONT;
            bdq_pkg::MODE_PUSH_REAR:  op_dec = bdq_pkg::OP_PUSH_REAR;
            bdq_pkg::MODE_POP_FRONT:  op_dec = bdq_pkg::OP_POP_FRONT;
            bdq_pkg::MODE_POP_REAR:   op_dec = bdq_pkg::OP_POP_REAR;
            bdq_pkg::MODE_LIST:       op_dec = bdq_pkg::OP_LIST;
            default:                  op_dec = bdq_pkg::OP_BAD;
        endcase
    end

    // The two-entry queue stalls the request channel only when both slots are taken.
    assign req_stall = (fill_reg == 2'd2);
    assign accept    = req_valid && !req_stall;
    assign q_valid   = (fill_reg != 2'd0);
    assign q_entry   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_take ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, accept} - {1'b0, q_take};
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue slots carry payload only.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg].op    <= op_dec;
            slot_reg[wr_ptr_reg].value <= value;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bdq_back.sv
// Back end: holds the word memory, head and count, and sequences each operation.
`default_nettype none

module bdq_back #(
    parameter int DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        capacity_we,
    input  wire logic [bdq_pkg::CAP_W-1:0]   capacity_wdata,
    input  wire logic                        q_valid,
    input  wire bdq_pkg::entry_t             q_entry,
    output logic                             q_take,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic signed [31:0]               value_res,
    output logic [2:0]                       status,
    output logic                             last
);

    localparam int HW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    // Circular index addition; both operands stay below DEPTH.
    function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] base,
                                               input logic [HW-1:0] off);
        logic [HW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (HW+1)'(DEPTH))
            s = s - (HW+1)'(DEPTH);
        return s[HW-1:0];
    endfunction

    logic signed [31:0]        mem [DEPTH];
    logic signed [31:0]        rd_data_reg;

    logic [1:0]                state_reg, state_next;
    logic [HW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [HW-1:0]             idx_reg, idx_next;
    logic [bdq_pkg::CAP_W-1:0] cap_reg;

    logic                      res_valid_reg, res_valid_next;
    logic signed [31:0]        value_res_reg, value_res_next;
    bdq_pkg::status_t          status_reg, status_next;
    logic                      last_reg, last_next;

    logic                      out_free;
    logic                      is_full;
    logic                      is_empty;
    logic [CMPW-1:0]           cap_eff;
    logic [HW-1:0]             head_dec;
    logic [HW-1:0]             head_inc;
    logic [HW-1:0]             tail_off;
    logic [HW-1:0]             idx_inc;
    logic                      list_last;
    logic                      mem_we;
    logic [HW-1:0]             mem_waddr;
    logic                      mem_re;
    logic [HW-1:0]             mem_raddr;

    // Clamp the capacity to the memory depth and derive the full and empty flags.
    always_comb
    begin
        cap_eff  = (CMPW'(cap_reg) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(cap_reg);
        is_full  = (CMPW'(count_reg) >= cap_eff);
        is_empty = (count_reg == CW'(0));
        head_dec = (head_reg == HW'(0)) ? HW'(DEPTH - 1) : head_reg - HW'(1);
        head_inc = wrap_add(head_reg, HW'(1));
        tail_off = HW'(count_reg - CW'(1));
        idx_inc  = idx_reg + HW'(1);
        list_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
    end

    // The output register can take a new result when empty or being drained.
    assign out_free = !res_valid_reg || !res_stall;
    assign q_take   = q_valid && (state_reg == S_IDLE) && out_free;

    // Operation sequencer.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg && res_stall;
        value_res_next = value_res_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = head_reg;
        mem_re         = 1'b0;
        mem_raddr      = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_take)
                begin
                    res_valid_next = 1'b1;
                    value_res_next = '0;
                    status_next    = bdq_pkg::ST_OK;
                    last_next      = 1'b1;
                    case (q_entry.op) inside
                        bdq_pkg::OP_PUSH_FRONT,
                        bdq_pkg::OP_PUSH_REAR:
                        begin
                            if (is_full)
                                status_next = bdq_pkg::ST_FULL;
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (q_entry.op == bdq_pkg::OP_PUSH_FRONT)
                                begin
                                    head_next = head_dec;
                                    mem_waddr = head_dec;
                                end
                                else
                                    mem_waddr = wrap_add(head_reg, HW'(count_reg));
                            end
                        end
                        bdq_pkg::OP_POP_FRONT,
                        bdq_pkg::OP_POP_REAR:
                        begin
                            if (is_empty)
                                status_next = bdq_pkg::ST_EMPTY;
                            else
                            begin
                                // The word is read into the read register and returned from S_READ.
                                res_valid_next = 1'b0;
                                mem_re         = 1'b1;
                                count_next     = count_reg - CW'(1);
                                state_next     = S_READ;
                                if (q_entry.op == bdq_pkg::OP_POP_FRONT)
                                begin
                                    mem_raddr = head_reg;
                                    head_next = head_inc;
                                end
                                else
                                    mem_raddr = wrap_add(head_reg, tail_off);
                            end
                        end
                        bdq_pkg::OP_LIST:
                        begin
                            if (is_empty)
                                status_next = bdq_pkg::ST_NOTHING;
                            else
                            begin
                                res_valid_next = 1'b0;
                                mem_re         = 1'b1;
                                mem_raddr      = head_reg;
                                idx_next       = '0;
                                state_next     = S_LIST;
                            end
                        end
                        default:
                            status_next = bdq_pkg::ST_BAD;
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    value_res_next = rd_data_reg;
                    status_next    = bdq_pkg::ST_OK;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LIST:
            begin
                // Emit one held word per cycle while the output register is free and prefetch the next one.
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    value_res_next = rd_data_reg;
                    status_next    = bdq_pkg::ST_OK;
                    last_next      = list_last;
                    if (list_last)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next  = idx_inc;
                        mem_re    = 1'b1;
                        mem_raddr = wrap_add(head_reg, idx_inc);
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state and the capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            cap_reg       <= bdq_pkg::CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            if (capacity_we)
                cap_reg <= capacity_wdata;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        value_res_reg <= value_res_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    // Word memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= q_entry.value;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign res_valid = res_valid_reg;
    assign value_res = value_res_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // The number of held words never exceeds the memory depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CMPW'(DEPTH))
        else $error("held word count exceeds depth");

    // While listing, the index always points at a held word.
    a_list_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (CW'(idx_reg) < count_reg))
        else $error("list index beyond held words");

    // A successful push adds exactly one word.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (q_take && !is_full && (q_entry.op == bdq_pkg::OP_PUSH_FRONT ||
                                q_entry.op == bdq_pkg::OP_PUSH_REAR))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not add one word");

    // No new request is taken while a read-backed result is in flight.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !q_take)
        else $error("request taken while sequencer busy");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the bounded double-ended queue core.
`default_nettype none

module testbench;

    localparam int DEPTH = 16;
    // Cycles to let the core settle after the last expected result.
    localparam int SETTLE = 10;
    localparam int CYCLE_LIMIT = 600000;

    // Request modes that the core must reject.
    localparam bdq_pkg::mode_t MODE_SPARE_5 = 3'd5;
    localparam bdq_pkg::mode_t MODE_SPARE_6 = 3'd6;
    localparam bdq_pkg::mode_t MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [31:0] word;
        bdq_pkg::status_t   code;
        logic               fin;
    } deque_result_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          capacity_we = 1'b0;
    logic [bdq_pkg::CAP_W-1:0]     capacity_wdata = '0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    bdq_pkg::mode_t                mode = bdq_pkg::MODE_PUSH_FRONT;
    logic signed [31:0]            value = '0;
    logic                          res_valid;
    logic                          res_stall = 1'b0;
    logic signed [31:0]            value_res;
    logic [2:0]                    status;
    logic                          last;

    // Shadow copy of the queue contents and the capacity register.
    logic [31:0]                   shadow_words [DEPTH];
    int                            shadow_head = 0;
    int                            shadow_held = 0;
    logic [bdq_pkg::CAP_W-1:0]     capacity_limit = bdq_pkg::CAP_RESET;

    deque_result_t                 pending_results [$];
    int                            errors = 0;
    int                            cycles = 0;
    int                            hold_request = 0;
    bit                            tx_calm = 1'b0;
    bit                            rx_calm = 1'b0;

    bounded_deque_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .capacity_we(capacity_we),
        .capacity_wdata(capacity_wdata),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .mode(mode),
        .value(value),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .value_res(value_res),
        .status(status),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run is cut off if it goes on far beyond the slowest correct run.
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[bounded_deque_core] ERROR");
        $finish;
    end

    // Mostly no pause, sometimes a short one, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void expect_result(logic [31:0] word, bdq_pkg::status_t code,
                                          logic fin);
        deque_result_t entry;
        entry.word = word;
        entry.code = code;
        entry.fin  = fin;
        pending_results.insert(pending_results.size(), entry);
    endfunction

    // Apply one accepted request to the shadow queue and record its results.
    function automatic void predict_request(bdq_pkg::mode_t m, logic [31:0] w);
        int room;
        int slot;
        room = (capacity_limit > DEPTH) ? DEPTH : int'(capacity_limit);
        case (m) inside
            bdq_pkg::MODE_PUSH_FRONT, bdq_pkg::MODE_PUSH_REAR:
            begin
                if (shadow_held >= room)
                    expect_result('0, bdq_pkg::ST_FULL, 1'b1);
                else
                begin
                    if (m == bdq_pkg::MODE_PUSH_FRONT)
                    begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_words[shadow_head] = w;
                    end
                    else
                        shadow_words[(shadow_head + shadow_held) % DEPTH] = w;
                    shadow_held++;
                    expect_result('0, bdq_pkg::ST_OK, 1'b1);
                end
            end
            bdq_pkg::MODE_POP_FRONT, bdq_pkg::MODE_POP_REAR:
            begin
                if (shadow_held == 0)
                    expect_result('0, bdq_pkg::ST_EMPTY, 1'b1);
                else
                begin
                    if (m == bdq_pkg::MODE_POP_FRONT)
                    begin
                        slot = shadow_head;
                        shadow_head = (shadow_head + 1) % DEPTH;
                    end
                    else
                        slot = (shadow_head + shadow_held - 1) % DEPTH;
                    shadow_held--;
                    expect_result(shadow_words[slot], bdq_pkg::ST_OK, 1'b1);
                end
            end
            bdq_pkg::MODE_LIST:
            begin
                if (shadow_held == 0)
                    expect_result('0, bdq_pkg::ST_NOTHING, 1'b1);
                else
                    for (int i = 0; i < shadow_held; i++)
                        expect_result(shadow_words[(shadow_head + i) % DEPTH],
                                      bdq_pkg::ST_OK, i == shadow_held - 1);
            end
            default:
                expect_result('0, bdq_pkg::ST_BAD, 1'b1);
        endcase
    endfunction

    // Result side: check every accepted result and choose the next stall.
    initial
    begin : result_sink
        int go_left;
        int stall_left;
        int hold_left;
        deque_result_t want;
        go_left = 0;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result value_res %0d status %0d last %0b",
                             $time, value_res, status, last);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (value_res !== want.word)
                    begin
                        $display("%0t: value_res expected %0d, actual %0d",
                                 $time, want.word, value_res);
                        errors++;
                    end
                    if (status !== want.code)
                    begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.code, status);
                        errors++;
                    end
                    if (last !== want.fin)
                    begin
                        $display("%0t: last expected %0b, actual %0b",
                                 $time, want.fin, last);
                        errors++;
                    end
                end
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (rx_calm)
                res_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else if (go_left > 0)
            begin
                go_left--;
                res_stall <= 1'b0;
            end
            else
            begin
                go_left = $urandom_range(1, 12);
                stall_left = pick_pause();
                res_stall <= 1'b0;
            end
        end
    end

    // Offer one request after a random gap (none while tx_calm is set) and wait until it is taken.
    task automatic send_request(input bdq_pkg::mode_t m, input logic signed [31:0] w);
        int gap;
        gap = tx_calm ? 0 : pick_pause();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        mode <= m;
        value <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_request(m, w);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic finish_outstanding();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [bdq_pkg::CAP_W-1:0] limit);
        finish_outstanding();
        capacity_we <= 1'b1;
        capacity_wdata <= limit;
        @(posedge clk);
        capacity_we <= 1'b0;
        capacity_limit = limit;
    endtask

    function automatic logic [31:0] random_word();
        if ($urandom_range(0, 7) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // An empty queue: list, pops at both ends and the rejected modes.
    task automatic test_empty_queue();
        send_request(bdq_pkg::MODE_LIST, 32'sd0);
        send_request(bdq_pkg::MODE_POP_FRONT, 32'sd0);
        send_request(bdq_pkg::MODE_POP_REAR, 32'sd0);
        send_request(MODE_SPARE_5, 32'sd0);
        send_request(MODE_SPARE_6, -32'sd1);
        send_request(MODE_SPARE_7, 32'sd0);
    endtask

    // Extreme words at both ends, with the head wrapping below zero.
    task automatic test_push_pop_ends();
        send_request(bdq_pkg::MODE_PUSH_FRONT, 32'sh8000_0000);
        send_request(bdq_pkg::MODE_PUSH_REAR, 32'sh7fff_ffff);
        send_request(bdq_pkg::MODE_PUSH_FRONT, -32'sd1);
        send_request(bdq_pkg::MODE_PUSH_REAR, 32'sd0);
        send_request(bdq_pkg::MODE_LIST, 32'sd0);
        send_request(bdq_pkg::MODE_POP_FRONT, 32'sd0);
        send_request(bdq_pkg::MODE_POP_REAR, 32'sd0);
    endtask

    // Capacity written below the held count keeps the words but refuses pushes.
    task automatic test_capacity_below_count();
        set_capacity(5'd1);
        send_request(bdq_pkg::MODE_PUSH_REAR, 32'sh1234_5678);
        send_request(bdq_pkg::MODE_POP_FRONT, 32'sd0);
        send_request(bdq_pkg::MODE_PUSH_FRONT, 32'sh0bad_cafe);
        send_request(bdq_pkg::MODE_POP_REAR, 32'sd0);
        send_request(bdq_pkg::MODE_PUSH_FRONT, 32'sh5a5a_5a5a);
        set_capacity(5'd0);
        send_request(bdq_pkg::MODE_PUSH_REAR, 32'sh2222_2222);
        send_request(bdq_pkg::MODE_POP_FRONT, 32'sd0);
        send_request(bdq_pkg::MODE_LIST, 32'sd0);
    endtask

    // The result side holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        set_capacity(bdq_pkg::CAP_RESET);
        tx_calm = 1'b1;
        hold_request = 80;
        for (int i = 0; i < 18; i++)
            send_request((i % 2) ? bdq_pkg::MODE_PUSH_REAR : bdq_pkg::MODE_PUSH_FRONT,
                         random_word());
        send_request(bdq_pkg::MODE_LIST, 32'sd0);
        for (int i = 0; i < 4; i++)
            send_request((i % 2) ? bdq_pkg::MODE_POP_REAR : bdq_pkg::MODE_POP_FRONT,
                         32'sd0);
        send_request(bdq_pkg::MODE_LIST, 32'sd0);
        tx_calm = 1'b0;
    endtask

    // One stretch of random requests under a given capacity and push share.
    task automatic run_random_phase(input logic [bdq_pkg::CAP_W-1:0] limit,
                                    input int items, input int push_pct, input bit calm);
        int r;
        bdq_pkg::mode_t m;
        set_capacity(limit);
        tx_calm = calm;
        rx_calm = calm;
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                m = $urandom_range(0, 1) ? bdq_pkg::MODE_PUSH_REAR
                                         : bdq_pkg::MODE_PUSH_FRONT;
            else if (r < 88)
                m = $urandom_range(0, 1) ? bdq_pkg::MODE_POP_REAR
                                         : bdq_pkg::MODE_POP_FRONT;
            else if (r < 96)
                m = bdq_pkg::MODE_LIST;
            else
                m = bdq_pkg::mode_t'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
            send_request(m, random_word());
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(5'd16, 50, 55, 1'b0);
        run_random_phase(5'd31, 40, 75, 1'b0);
        run_random_phase(5'd3, 30, 50, 1'b1);
        run_random_phase(5'd0, 10, 40, 1'b0);
        run_random_phase(5'd17, 30, 65, 1'b0);
        run_random_phase(bdq_pkg::CAP_RESET, 40, 45, 1'b0);
    endtask

    initial
    begin : run
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_empty_queue();
        test_push_pop_ends();
        test_capacity_below_count();
        test_backpressure();
        test_random_traffic();
        finish_outstanding();
        if (errors == 0)
            $display("[bounded_deque_core] OK");
        else
            $display("[bounded_deque_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
